// ----- hw/rtl/learning_forwarding_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the learning forwarding table
// Clocked property checks with synchronous reset disable, same-cycle and
// next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef LEARNING_FORWARDING_TABLE_ASSERT_SVH
`define LEARNING_FORWARDING_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lft_pkg.sv -----
// ----------------------------------------------------------------------------
// Learning forwarding table package
// Field widths, action and command codes, transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package lft_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int NUM_PORTS             = 8;
   localparam int CMD_FIFO_DEPTH        = 2;
   localparam int RSP_FIFO_DEPTH        = 2;

   localparam int ACTION_W = 2;
   localparam int PORT_W   = 3;
   localparam int ADDR_W   = 32;
   localparam int HOP_W    = 8;
   localparam int MASK_W   = 8;

   // ports that physically exist
   localparam logic [MASK_W-1:0] PORT_EXIST = (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}}
                                              : MASK_W'((1 << NUM_PORTS) - 1);
   localparam logic [MASK_W-1:0] PORT_ENABLE_RESET = {MASK_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_PACKET    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INTRO     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PORT_DOWN = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_FORWARD,
      OP_DROP,
      OP_INTRO,
      OP_PORT_DOWN
   } op_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PORT_W-1:0]   ingress_port;
      logic [ADDR_W-1:0]   source_address;
      logic [ADDR_W-1:0]   dest_address;
      logic [HOP_W-1:0]    hop_count;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] forward_mask;
      logic [HOP_W-1:0]  hop_out;
      logic              dropped;
      logic              flooded;
      logic              table_full;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [PORT_W-1:0] ingress_port;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] dest_address;
      logic [HOP_W-1:0]  hop_out;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lft_fifo.sv -----
// ----------------------------------------------------------------------------
// Small flop-based queue
// First-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

`include "learning_forwarding_table_assert.svh"

module lft_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_MAX);
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `LFT_ASSERT_SAME(a_fifo_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX, "fifo overfilled")
   `LFT_ASSERT_NEXT(a_fifo_push_grows, clock, reset, push_ok && !pop_ok, count_ff == $past(count_ff) + CNT_W'(1), "fifo push lost")
   `LFT_ASSERT_NEXT(a_fifo_both_hold, clock, reset, push_ok && pop_ok, $stable(count_ff), "fifo count moved on push and pop")

endmodule

`default_nettype wire

// ----- hw/rtl/lft_front.sv -----
// ----------------------------------------------------------------------------
// Learning forwarding table front end
// Accepts request transactions and classifies them into table commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lft_front import lft_pkg::*; (
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_item,
   input  wire logic    cmd_full,
   output logic         cmd_push,
   output cmd_type      cmd
);

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      cmd.ingress_port   = req_item.ingress_port;
      cmd.source_address = req_item.source_address;
      cmd.dest_address   = req_item.dest_address;
      cmd.hop_out        = req_item.hop_count - HOP_W'(1);
      case (req_item.action)
         ACT_PACKET: begin
            cmd.op = (req_item.hop_count == '0) ? OP_DROP : OP_FORWARD;
         end
         ACT_INTRO:     cmd.op = OP_INTRO;
         ACT_PORT_DOWN: cmd.op = OP_PORT_DOWN;
         default:       cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lft_back.sv -----
// ----------------------------------------------------------------------------
// Learning forwarding table back end
// Holds the address table, learns, looks up and builds the response.
// ----------------------------------------------------------------------------
`default_nettype none

`include "learning_forwarding_table_assert.svh"

module lft_back import lft_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [MASK_W-1:0] port_enable,
   input  wire logic              cmd_empty,
   input  wire cmd_type           cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output rsp_type                rsp
);

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0]        addr_ff [TABLE_ENTRIES];
   logic [PORT_W-1:0]        port_ff [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] src_hit, dst_hit, port_match;
   logic [TABLE_ENTRIES-1:0] free_vec, first_free, wr_vec, erase_vec;
   logic [PORT_W-1:0]        dst_port;
   logic                     do_cmd, learn_op, learned, same_addr;
   logic [MASK_W-1:0]        flood_mask, uni_mask;

   assign do_cmd   = !cmd_empty && !rsp_full;
   assign cmd_pop  = do_cmd;
   assign rsp_push = do_cmd;

   // per-entry compares
   always_comb begin
      dst_port = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         src_hit[i]    = valid_ff[i] && (addr_ff[i] == cmd.source_address);
         dst_hit[i]    = valid_ff[i] && (addr_ff[i] == cmd.dest_address);
         port_match[i] = valid_ff[i] && (port_ff[i] == cmd.ingress_port);
         dst_port      = dst_port | (dst_hit[i] ? port_ff[i] : '0);
      end
   end

   // lowest free entry as a one-hot vector
   assign free_vec   = ~valid_ff;
   assign first_free = free_vec & (~free_vec + TABLE_ENTRIES'(1));
   assign wr_vec     = (|src_hit) ? src_hit : first_free;
   assign learned    = |wr_vec;
   assign same_addr  = (cmd.source_address == cmd.dest_address);
   assign learn_op   = (cmd.op == OP_FORWARD) || (cmd.op == OP_DROP) || (cmd.op == OP_INTRO);

   assign flood_mask = port_enable & ~(MASK_W'(1) << cmd.ingress_port) & PORT_EXIST;
   assign uni_mask   = (MASK_W'(1) << dst_port) & PORT_EXIST;

   always_comb begin
      rsp       = '0;
      erase_vec = '0;
      case (cmd.op)
         OP_FORWARD: begin
            rsp.hop_out    = cmd.hop_out;
            rsp.table_full = !learned;
            if (same_addr && learned) begin
               // destination is the source just learned on ingress: loop
               erase_vec    = wr_vec;
               rsp.flooded  = 1'b1;
               rsp.forward_mask = flood_mask;
            end else if ((|dst_hit) && (dst_port != cmd.ingress_port)) begin
               rsp.forward_mask = uni_mask;
            end else begin
               erase_vec    = dst_hit;
               rsp.flooded  = 1'b1;
               rsp.forward_mask = flood_mask;
            end
         end
         OP_DROP: begin
            rsp.dropped    = 1'b1;
            rsp.table_full = !learned;
         end
         OP_INTRO: begin
            rsp.table_full = !learned;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (do_cmd) begin
         if (learn_op) begin
            valid_in = valid_in | wr_vec;
         end
         if (cmd.op == OP_PORT_DOWN) begin
            valid_in = valid_in & ~port_match;
         end
         valid_in = valid_in & ~erase_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (do_cmd && learn_op && wr_vec[i]) begin
            addr_ff[i] <= cmd.source_address;
            port_ff[i] <= cmd.ingress_port;
         end
      end
   end

   `LFT_ASSERT_SAME(a_full_means_no_room, clock, reset, do_cmd && learn_op && !learned, &valid_ff, "table full reported with a free entry")
   `LFT_ASSERT_SAME(a_port_down_clears, clock, reset, do_cmd && (cmd.op == OP_PORT_DOWN), !(|(valid_in & port_match)), "entry survived port down")
   `LFT_ASSERT_NEXT(a_intro_keeps_entries, clock, reset, do_cmd && (cmd.op == OP_INTRO), $countones(valid_ff) >= $past($countones(valid_ff)), "intro removed an entry")

endmodule

`default_nettype wire

// ----- hw/rtl/learning_forwarding_table.sv -----
// Flow: an accepted request is registered in the command queue; the back end does the table
// work on the queue head and its response is registered in the response queue, which drives
// the rsp_ ports. Throughput: one transaction per cycle while the response queue has room,
// with the address table compare and update decided combinationally in the back end.
// Reset (synchronous): empties both queues and the table, sets port_enable to all ones;
// no clearing pass, requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
// Learning forwarding table
// Learns source addresses per ingress port, drops packets with a zero hop count and
// forwards or floods the rest by destination lookup; port-down requests flush a port's entries.
// ----------------------------------------------------------------------------
`default_nettype none

module learning_forwarding_table import lft_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request side
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire req_type           req_item,
   // response side
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output rsp_type                rsp_item,
   // control register write
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [MASK_W-1:0] csr_data
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [MASK_W-1:0] port_enable_ff, port_enable_in;

   logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type           cmd_in, cmd_out;
   logic [CMD_W-1:0]  cmd_rdata;

   logic              rsp_push, rsp_full;
   rsp_type           rsp_in;
   logic [RSP_W-1:0]  rsp_rdata;

   // Always ready; the user must write the register only with the block idle; not enforced.
   assign csr_ready = 1'b1;

   always_comb begin
      port_enable_in = port_enable_ff;
      if (csr_valid && csr_ready) begin
         port_enable_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_enable_ff <= PORT_ENABLE_RESET;
      end else begin
         port_enable_ff <= port_enable_in;
      end
   end

   // Front end: decode action and hop count into a table command.
   lft_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   // Command queue: decouple intake from table work.
   lft_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .wdata (cmd_in),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rdata)
   );

   assign cmd_out = cmd_type'(cmd_rdata);

   // Back end: learn, look up, erase and build the response for the queue head;
   // advance only when the response queue has room.
   lft_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .port_enable (port_enable_ff),
      .cmd_empty   (cmd_empty),
      .cmd         (cmd_out),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (rsp_in)
   );

   // Response queue: hold finished transactions until popped.
   lft_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_in),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_rdata)
   );

   assign rsp_item = rsp_type'(rsp_rdata);

endmodule

`default_nettype wire

// ----- tb/tb_learning_forwarding_table.sv -----
// ----------------------------------------------------------------------------
// Learning forwarding table testbench
// Runs a directed sequence of learning, forwarding, flooding, drop, port-down
// and table-overflow cases, then random traffic over a small address pool,
// across several port_enable values. A class mirrors the address table and
// checks every response in order against its own forwarding decision. Both
// queue sides idle at random, with long receiver hold-offs in some phases.
// ----------------------------------------------------------------------------

module tb_learning_forwarding_table;
   timeunit 1ns;
   timeprecision 1ps;

   import lft_pkg::*;

   localparam int SLOTS       = TABLE_ENTRIES_DEFAULT;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 105;
   localparam int FILL_ITEMS  = 20;
   localparam int DRAIN_WAIT  = 8;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [MASK_W-1:0]   ONE_PORT   = 1;

   // Mirror of the address table; predicts one forwarding decision per
   // accepted request and checks responses against them in order.
   class fwd_decision_checker;
      rsp_type           pending_decisions[$];
      logic [MASK_W-1:0] port_enable;
      bit                slot_valid[SLOTS];
      logic [ADDR_W-1:0] slot_addr[SLOTS];
      logic [PORT_W-1:0] slot_port[SLOTS];
      int                mismatches;

      function new();
         port_enable = PORT_ENABLE_RESET;
         mismatches  = 0;
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_port[i]  = '0;
         end
      endfunction

      function int find_slot(logic [ADDR_W-1:0] addr);
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_addr[i] == addr) return i;
         end
         return -1;
      endfunction

      // Returns 1 when a new source finds no free slot.
      function bit learn_source(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
         int hit;
         hit = find_slot(addr);
         if (hit >= 0) begin
            slot_port[hit] = port;
            return 1'b0;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) begin
               slot_valid[i] = 1'b1;
               slot_addr[i]  = addr;
               slot_port[i]  = port;
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void note_request(req_type req);
         rsp_type decision;
         int      hit;
         decision = '0;
         case (req.action)
            ACT_PACKET, ACT_INTRO: begin
               decision.table_full = learn_source(req.source_address, req.ingress_port);
               if (req.action == ACT_PACKET) begin
                  if (req.hop_count == '0) begin
                     decision.dropped = 1'b1;
                  end else begin
                     decision.hop_out = req.hop_count - 1'b1;
                     hit = find_slot(req.dest_address);
                     if (hit >= 0 && slot_port[hit] != req.ingress_port) begin
                        decision.forward_mask = ONE_PORT << slot_port[hit];
                     end else begin
                        if (hit >= 0) slot_valid[hit] = 1'b0;
                        decision.flooded      = 1'b1;
                        decision.forward_mask = port_enable & ~(ONE_PORT << req.ingress_port);
                     end
                     decision.forward_mask &= PORT_EXIST;
                  end
               end
            end
            ACT_PORT_DOWN: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i] && slot_port[i] == req.ingress_port) slot_valid[i] = 1'b0;
               end
            end
            default: ;
         endcase
         pending_decisions = {pending_decisions, decision};
      endfunction

      function void check_decision(rsp_type got);
         rsp_type want;
         if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with nothing expected: %h", got);
            return;
         end
         want = pending_decisions.pop_front();
         if (got.forward_mask !== want.forward_mask || got.hop_out !== want.hop_out ||
             got.dropped !== want.dropped || got.flooded !== want.flooded ||
             got.table_full !== want.table_full) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp/act: mask %h/%h hop %h/%h drop %b/%b flood %b/%b full %b/%b",
                        want.forward_mask, got.forward_mask, want.hop_out, got.hop_out,
                        want.dropped, got.dropped, want.flooded, got.flooded,
                        want.table_full, got.table_full);
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   req_type           req_item  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rsp_type           rsp_item;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MASK_W-1:0] csr_data  = '0;

   fwd_decision_checker sb = new();

   int                cycle_count   = 0;
   int                long_hold_req = 0;   // set by the sender, consumed by the receiver
   int                burst_left    = 0;
   bit                back_to_back  = 1'b0;
   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

   learning_forwarding_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watch both queue handshakes at the edge; inputs are driven with
   // nonblocking assignments, so the values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_request(req_item);
         if (rsp_pop && !rsp_empty) sb.check_decision(rsp_item);
      end
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: switch between draining freely, coin-flip popping and
   // occasional stall runs; honor a long hold-off when the sender asks for one.
   initial begin : receiver
      int mode;
      int mode_left;
      int stall_left;
      int hold_left;
      mode       = 0;
      mode_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req != 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= ($urandom_range(0, 1) == 1);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_pop <= 1'b0;
                  end else if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(1, 12);
                     rsp_pop <= 1'b0;
                  end else begin
                     rsp_pop <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   function automatic req_type make_req(logic [ACTION_W-1:0] action, logic [PORT_W-1:0] port,
                                        logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                        logic [HOP_W-1:0] hops);
      req_type r;
      r.action         = action;
      r.ingress_port   = port;
      r.source_address = src;
      r.dest_address   = dst;
      r.hop_count      = hops;
      return r;
   endfunction

   // Mostly pool addresses so that lookups hit; some fresh ones to churn the table.
   function automatic logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 3) != 0) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      return ADDR_W'($urandom);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.ingress_port   = PORT_W'($urandom_range(0, 7));
      r.source_address = pick_address();
      r.dest_address   = ($urandom_range(0, 9) == 0) ? r.source_address : pick_address();
      pick = $urandom_range(0, 19);
      case (pick)
         0:       r.hop_count = '0;
         1:       r.hop_count = 8'd1;
         2:       r.hop_count = '1;
         default: r.hop_count = HOP_W'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 72)      r.action = ACT_PACKET;
      else if (pick < 88) r.action = ACT_INTRO;
      else if (pick < 96) r.action = ACT_PORT_DOWN;
      else                r.action = ACT_UNUSED;
      return r;
   endfunction

   // Offer one transaction and hold it until the block takes it. Leave push
   // high so that a following transaction goes out back to back.
   task automatic send_request(input req_type r);
      req_push <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_full !== 1'b0);
   endtask

   // Send, then either continue the burst or, outside back-to-back mode, drop push for a random gap.
   task automatic send_paced(input req_type r);
      send_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (!back_to_back) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // Drop push and hold until every expected response has been popped.
   // The extra edge lets the monitor record a transaction taken at this edge.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending_decisions.size() != 0) @(posedge clock);
   endtask

   // Write port_enable only with the block idle; every request yields one
   // response, so an empty expectation queue means nothing is in flight.
   task automatic write_port_enable(input logic [MASK_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.port_enable = value;
   endtask

   initial begin : stimulus
      int                sent;
      bit                midway_pause;
      int                k;
      logic [MASK_W-1:0] enable_value;

      foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
      addr_pool[0] = '0;
      addr_pool[1] = '1;

      // Hold reset at the start, then release it once.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Flood to an unknown destination, then unicast back to a learned source.
      send_paced(make_req(ACT_PACKET, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF));
      send_paced(make_req(ACT_PACKET, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 8'h01));
      // Zero hops: drop, but still move the source to a new port.
      send_paced(make_req(ACT_PACKET, 3'd3, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00));
      // Intro only learns.
      send_paced(make_req(ACT_INTRO, 3'd5, 32'h1234_5678, ADDR_W'($urandom), HOP_W'($urandom)));
      send_paced(make_req(ACT_PACKET, 3'd2, 32'hA5A5_A5A5, 32'h1234_5678, 8'h80));
      // Destination learned on the ingress port: erase it and flood.
      send_paced(make_req(ACT_PACKET, 3'd5, 32'h5A5A_5A5A, 32'h1234_5678, 8'h02));
      // Destination equal to source: learned first, then found on ingress.
      send_paced(make_req(ACT_PACKET, 3'd1, 32'h0BAD_0BAD, 32'h0BAD_0BAD, 8'h07));
      // Port down clears what port 7 learned; the next lookup floods.
      send_paced(make_req(ACT_PORT_DOWN, 3'd7, ADDR_W'($urandom), ADDR_W'($urandom),
                          HOP_W'($urandom)));
      send_paced(make_req(ACT_PACKET, 3'd4, 32'hC3C3_C3C3, 32'hFFFF_FFFF, 8'h03));
      // Unused action code does nothing.
      send_paced(make_req(ACT_UNUSED, 3'd6, ADDR_W'($urandom), ADDR_W'($urandom),
                          HOP_W'($urandom)));

      // Fill the table, then overflow it with a new source.
      for (int i = 0; i < SLOTS - 4; i++)
         send_paced(make_req(ACT_INTRO, PORT_W'(i), 32'hF00D_0000 | i, 32'h0, 8'h0));
      send_paced(make_req(ACT_PACKET, 3'd6, 32'h7E57_0001, 32'h0000_0000, 8'h09));

      // All ports disabled: flooding reaches nobody, unicast still goes out.
      write_port_enable('0);
      send_paced(make_req(ACT_PACKET, 3'd0, 32'h0000_0000, 32'hDEAD_BEEF, 8'h04));
      send_paced(make_req(ACT_PACKET, 3'd6, 32'h7E57_0002, 32'hA5A5_A5A5, 8'h05));

      for (int phase = 0; phase < PHASES; phase++) begin
         k = $urandom_range(0, NUM_PORTS - 1);
         case ((phase + 1) % 5)
            0:       enable_value = '0;
            1:       enable_value = '1;
            2:       enable_value = ONE_PORT << k;
            3:       enable_value = ~(ONE_PORT << k);
            default: enable_value = MASK_W'($urandom);
         endcase
         write_port_enable(enable_value);

         // Now and then stall the receiver for a long stretch while the
         // sender keeps pushing, so the queues back up into req_full.
         if (phase % 4 == 1) begin
            long_hold_req = $urandom_range(150, 300);
            back_to_back  = 1'b1;
         end
         midway_pause = (phase % 3 == 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (back_to_back && sent >= 48) back_to_back = 1'b0;
            if (midway_pause && sent >= 52) begin
               wait_drained();
               midway_pause = 1'b0;
            end
            if ($urandom_range(0, 49) == 0) begin
               // Burst of fresh intros to drive the table into overflow.
               for (int i = 0; i < FILL_ITEMS; i++)
                  send_paced(make_req(ACT_INTRO, PORT_W'($urandom_range(0, 7)),
                                      ADDR_W'($urandom), ADDR_W'($urandom),
                                      HOP_W'($urandom)));
               sent += FILL_ITEMS;
            end else begin
               send_paced(random_request());
               sent++;
            end
         end
      end

      // Drain, then keep watching the response side for stray responses before the verdict.
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_decisions.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- learning_forwarding_table.f -----
+incdir+hw/rtl
hw/rtl/lft_pkg.sv
hw/rtl/lft_fifo.sv
hw/rtl/lft_front.sv
hw/rtl/lft_back.sv
hw/rtl/learning_forwarding_table.sv
tb/tb_learning_forwarding_table.sv
